>>> hw/rtl/plti_pkg.sv
// Shared types and constants for the piecewise-linear table interpolation unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package plti_pkg;

  localparam int unsigned MAX_POINTS = 64;
  localparam int unsigned IDX_W      = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W      = $clog2(MAX_POINTS + 1);
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned DIV_STEPS  = 2 * DATA_W;
  localparam int unsigned STEP_W     = $clog2(DIV_STEPS);

  typedef enum logic {
    MODE_LOAD  = 1'b0,
    MODE_QUERY = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_EMPTY      = 2'd1,
    STAT_NO_IVAL    = 2'd2,
    STAT_ZERO_WIDTH = 2'd3
  } status_e;

  typedef struct packed {
    logic                     mode;
    logic [5:0]               point_index;
    logic [31:0]              time_value;
    logic signed [31:0]       point_amplitude;
  } req_t;

  typedef struct packed {
    logic signed [31:0]       amplitude;
    logic [1:0]               status;
  } rsp_t;

  typedef struct packed {
    logic [DATA_W-1:0]        bp_time;
    logic [DATA_W-1:0]        bp_amp;
  } entry_t;

  typedef struct packed {
    logic [DATA_W-1:0]        mag;
    logic [DATA_W-1:0]        dt;
    logic [DATA_W-1:0]        width;
  } scale_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_CLAMP,
    S_SCAN,
    S_DIV
  } ctrl_state_e;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_DIV,
    SC_DONE
  } scale_state_e;

endpackage

>>> hw/rtl/plti_scale.sv
// Scaling unit: registered 32x32 multiply, then a restoring 64/32 divide, one bit a cycle.
// Depends on plti_pkg.
`timescale 1ns / 1ps

module plti_scale import plti_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  scale_req_t        req_i,
  output logic              done_o,
  output logic [DATA_W-1:0] quot_o
);

  scale_state_e              state_q, state_d;
  logic [DATA_W-1:0]         mag_q, dt_q, width_q;
  logic [2*DATA_W-1:0]       quo_q, quo_d;
  logic [DATA_W-1:0]         rem_q, rem_d;
  logic [STEP_W-1:0]         step_q, step_d;
  logic [DATA_W:0]           rem_sh;
  logic                      ge;

  assign rem_sh = {rem_q, quo_q[2*DATA_W-1]};
  assign ge     = rem_sh >= {1'b0, width_q};

  always_comb begin
    state_d = state_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    step_d  = step_q;
    unique case (state_q)
      SC_IDLE: begin
        if (start_i) begin
          state_d = SC_MUL;
        end
      end
      SC_MUL: begin
        quo_d   = (2*DATA_W)'(mag_q) * (2*DATA_W)'(dt_q);
        rem_d   = '0;
        step_d  = '0;
        state_d = SC_DIV;
      end
      SC_DIV: begin
        rem_d  = ge ? DATA_W'(rem_sh - {1'b0, width_q}) : rem_sh[DATA_W-1:0];
        quo_d  = {quo_q[2*DATA_W-2:0], ge};
        step_d = step_q + 1'b1;
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          state_d = SC_DONE;
        end
      end
      SC_DONE: begin
        state_d = SC_IDLE;
      end
      default: state_d = SC_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == SC_IDLE && start_i) begin
      mag_q   <= req_i.mag;
      dt_q    <= req_i.dt;
      width_q <= req_i.width;
    end
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o = state_q == SC_DONE;
  assign quot_o = quo_q[DATA_W-1:0];

endmodule

>>> hw/rtl/piecewise_linear_table_interp_unit.sv
// Top level of the piecewise-linear table interpolation unit: breakpoint memory and query walk.
// Depends on plti_pkg and plti_scale.
`timescale 1ns / 1ps

// Usage:
//   A request is taken at a rising edge with start high and busy low. A load request
//   (mode 0) writes one breakpoint (time, amplitude) into slot point_index in that same
//   cycle and gives no result; busy stays low, so a request may follow every cycle.
//   A query request (mode 1) returns one result on res_o, marked by res_valid_o for
//   exactly one cycle; the receiver cannot stall and must take it then.
//   A query to an empty table is answered straight from idle. Otherwise the sequencer
//   reads the last breakpoint, then the first, and clamps to either end; else it scans
//   the intervals from slot 1 upward until one holds the time or the table ends.
//   The sequencer reads one breakpoint a cycle from the table memory, which has one
//   write port and one read port, and a nonzero-width interval adds a registered
//   multiply and a 64-step bit-serial divide. For a query to a nonempty table, busy
//   stays high from acceptance until the cycle the result appears; a new request
//   may be taken in the cycle the result is shown.
//   points_in_use is to be written through cfg_we_i/cfg_wdata_i only while idle; the
//   block itself does not enforce this. Values above 64 act as 64. Reset clears
//   points_in_use and the sequencer; the table is undefined until loaded, and no
//   clearing pass runs.
module piecewise_linear_table_interp_unit import plti_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  req_t             req_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  output logic             res_valid_o,
  output rsp_t             res_o
);

  entry_t            mem [MAX_POINTS];
  entry_t            rd_q;
  logic [IDX_W-1:0]  rd_addr;

  ctrl_state_e       state_q, state_d;
  logic [CNT_W-1:0]  pts_q, n_sat, n_m1;
  logic [IDX_W-1:0]  k_q, k_d;
  logic [DATA_W-1:0] t_q;
  entry_t            last_q, last_d, prev_q, prev_d;
  logic              neg_q, neg_d;
  rsp_t              res_q, res_d;
  logic              res_valid_q, res_valid_d;

  logic              accept, load_we;
  logic              scale_start, scale_done;
  scale_req_t        scale_req;
  logic [DATA_W-1:0] scale_quot;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] adj;

  assign accept  = start && !busy;
  assign load_we = accept && req_i.mode == MODE_LOAD;
  assign n_sat   = (pts_q > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : pts_q;
  assign n_m1    = n_sat - 1'b1;
  assign diff    = {rd_q.bp_amp[DATA_W-1], rd_q.bp_amp}
                 - {prev_q.bp_amp[DATA_W-1], prev_q.bp_amp};
  assign adj     = neg_q ? DATA_W'(~scale_quot + 1'b1) : scale_quot;

  always_ff @(posedge clk_i) begin
    if (load_we) begin
      mem[req_i.point_index] <= '{bp_time: req_i.time_value, bp_amp: req_i.point_amplitude};
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    last_d      = last_q;
    prev_d      = prev_q;
    neg_d       = neg_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    rd_addr     = '0;
    scale_start = 1'b0;
    scale_req   = '{mag: '0, dt: '0, width: '0};
    unique case (state_q)
      S_IDLE: begin
        if (accept && req_i.mode == MODE_QUERY) begin
          if (n_sat == '0) begin
            res_d       = '{amplitude: '0, status: STAT_EMPTY};
            res_valid_d = 1'b1;
          end else begin
            rd_addr = n_m1[IDX_W-1:0];
            state_d = S_FIRST;
          end
        end
      end
      S_FIRST: begin
        last_d  = rd_q;
        rd_addr = '0;
        state_d = S_CLAMP;
      end
      S_CLAMP: begin
        if (t_q <= rd_q.bp_time) begin
          res_d       = '{amplitude: rd_q.bp_amp, status: STAT_OK};
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (t_q >= last_q.bp_time) begin
          res_d       = '{amplitude: last_q.bp_amp, status: STAT_OK};
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          prev_d  = rd_q;
          k_d     = IDX_W'(1);
          rd_addr = IDX_W'(1);
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (t_q >= prev_q.bp_time && t_q <= rd_q.bp_time) begin
          if (rd_q.bp_time == prev_q.bp_time) begin
            res_d       = '{amplitude: prev_q.bp_amp, status: STAT_ZERO_WIDTH};
            res_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            neg_d           = diff[DATA_W];
            scale_start     = 1'b1;
            scale_req.mag   = diff[DATA_W] ? DATA_W'(~diff + 1'b1) : diff[DATA_W-1:0];
            scale_req.dt    = t_q - prev_q.bp_time;
            scale_req.width = rd_q.bp_time - prev_q.bp_time;
            state_d         = S_DIV;
          end
        end else if (k_q == n_m1[IDX_W-1:0]) begin
          res_d       = '{amplitude: '0, status: STAT_NO_IVAL};
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else begin
          prev_d  = rd_q;
          k_d     = k_q + 1'b1;
          rd_addr = k_q + 1'b1;
        end
      end
      S_DIV: begin
        if (scale_done) begin
          res_d       = '{amplitude: prev_q.bp_amp + adj, status: STAT_OK};
          res_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pts_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        pts_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      t_q <= req_i.time_value;
    end
    k_q    <= k_d;
    last_q <= last_d;
    prev_q <= prev_d;
    neg_q  <= neg_d;
    res_q  <= res_d;
  end

  plti_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scale_start),
    .req_i   (scale_req),
    .done_o  (scale_done),
    .quot_o  (scale_quot)
  );

  assign busy        = state_q != S_IDLE;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  a_res_from_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q |-> $past(state_q != S_IDLE || (start && req_i.mode == MODE_QUERY)))
    else $error("result without a query");

  a_load_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && start && req_i.mode == MODE_LOAD) |=> !res_valid_q)
    else $error("load produced a result");

  a_busy_ends_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> res_valid_q)
    else $error("query ended without a result");

  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |-> ({1'b0, k_q} <= n_m1 && k_q != '0))
    else $error("scan index out of table");

endmodule

>>> sim/plti_checker.sv
// Checker for the piecewise-linear table interpolation unit: watches requests, configuration
// writes and results, predicts each query answer and compares it field by field.
// Depends on plti_pkg.
`timescale 1ns / 1ps

module plti_checker import plti_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic             busy_i,
  input  req_t             req_i,
  input  logic             cfg_we_i,
  input  logic [CNT_W-1:0] cfg_wdata_i,
  input  logic             res_valid_i,
  input  rsp_t             res_i,
  output int unsigned      mismatch_count_o,
  output int unsigned      pending_o
);

  localparam int unsigned PRINT_CAP = 50;

  logic [DATA_W-1:0]        bp_times [MAX_POINTS];
  logic signed [DATA_W-1:0] bp_amps  [MAX_POINTS];
  logic [CNT_W-1:0]         points_cfg;
  rsp_t                     expected_rsp [$];
  rsp_t                     oldest_rsp;
  int unsigned              mismatches = 0;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t plti_checker: %s", $time, msg);
  endtask

  function automatic rsp_t interp_amplitude(input logic [DATA_W-1:0] t);
    rsp_t              r;
    int unsigned       n;
    logic [DATA_W-1:0] tk;
    logic [DATA_W-1:0] tk1;
    logic [DATA_W-1:0] width;
    logic [DATA_W-1:0] dt;
    longint            diff;
    longint            q;
    logic [63:0]       mag;
    logic [63:0]       prod;
    r.amplitude = '0;
    r.status    = STAT_OK;
    n = (points_cfg > MAX_POINTS) ? MAX_POINTS : points_cfg;
    if (n == 0) begin
      r.status = STAT_EMPTY;
      return r;
    end
    if (t <= bp_times[0]) begin
      r.amplitude = bp_amps[0];
      return r;
    end
    if (t >= bp_times[n-1]) begin
      r.amplitude = bp_amps[n-1];
      return r;
    end
    for (int k = 0; k + 1 < n; k++) begin
      tk  = bp_times[k];
      tk1 = bp_times[k+1];
      if (t >= tk && t <= tk1) begin
        width = tk1 - tk;
        if (width == 0) begin
          r.amplitude = bp_amps[k];
          r.status    = STAT_ZERO_WIDTH;
          return r;
        end
        dt   = t - tk;
        diff = longint'(bp_amps[k+1]) - longint'(bp_amps[k]);
        mag  = (diff < 0) ? -diff : diff;
        prod = mag * {32'd0, dt};
        q    = longint'(prod / {32'd0, width});
        if (diff < 0) q = -q;
        r.amplitude = 32'(longint'(bp_amps[k]) + q);
        return r;
      end
    end
    r.amplitude = '0;
    r.status    = STAT_NO_IVAL;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      points_cfg = '0;
      expected_rsp.delete();
      for (int i = 0; i < MAX_POINTS; i++) begin
        bp_times[i] = '0;
        bp_amps[i]  = '0;
      end
    end else begin
      if (res_valid_i) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch($sformatf("result with none pending: amplitude %h status %0d",
                                    res_i.amplitude, res_i.status));
        end else begin
          oldest_rsp = expected_rsp.pop_front();
          if (res_i.amplitude !== oldest_rsp.amplitude)
            report_mismatch($sformatf("amplitude %h, want %h",
                                      res_i.amplitude, oldest_rsp.amplitude));
          if (res_i.status !== oldest_rsp.status)
            report_mismatch($sformatf("status %0d, want %0d",
                                      res_i.status, oldest_rsp.status));
        end
      end
      if (cfg_we_i) points_cfg = cfg_wdata_i;
      if (start_i && !busy_i) begin
        if (req_i.mode == MODE_QUERY) begin
          expected_rsp.insert(expected_rsp.size(), interp_amplitude(req_i.time_value));
        end else if (req_i.point_index < MAX_POINTS) begin
          bp_times[req_i.point_index] = req_i.time_value;
          bp_amps[req_i.point_index]  = req_i.point_amplitude;
        end
      end
    end
    pending_o        <= expected_rsp.size();
    mismatch_count_o <= mismatches;
  end

endmodule

>>> sim/tb_piecewise_linear_table_interp_unit.sv
// Testbench top for the piecewise-linear table interpolation unit: resets the block, loads
// tables of many sizes and shapes, issues queries in random bursts and gives the verdict.
// Depends on plti_pkg, plti_checker and piecewise_linear_table_interp_unit.
`timescale 1ns / 1ps

module tb_piecewise_linear_table_interp_unit;
  import plti_pkg::*;

  localparam int unsigned ITEM_TARGET = 700;
  localparam int unsigned TAIL_CYCLES = 150;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  req_t             req_i;
  logic             cfg_we_i;
  logic [CNT_W-1:0] cfg_wdata_i;
  logic             res_valid_o;
  rsp_t             res_o;

  int unsigned       mismatch_count;
  int unsigned       pending_count;
  logic [DATA_W-1:0] shadow_time [MAX_POINTS];
  int unsigned       active_n;
  int unsigned       burst_left;
  int unsigned       items_sent;
  int unsigned       loads_sent;
  int unsigned       queries_sent;
  int unsigned       table_settings;

  piecewise_linear_table_interp_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  plti_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .req_i            (req_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .res_valid_i      (res_valid_o),
    .res_i            (res_o),
    .mismatch_count_o (mismatch_count),
    .pending_o        (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("tb_piecewise_linear_table_interp_unit: errors");
    $finish;
  end

  task automatic pace();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        9:       gap = $urandom_range(20, 90);
        default: gap = $urandom_range(1, 8);
      endcase
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic send_request(input req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    items_sent++;
    pace();
  endtask

  task automatic load_point(input logic [5:0] slot, input logic [31:0] t,
                            input logic [31:0] a);
    req_t r;
    r.mode            = MODE_LOAD;
    r.point_index     = slot;
    r.time_value      = t;
    r.point_amplitude = a;
    shadow_time[slot] = t;
    loads_sent++;
    send_request(r);
  endtask

  task automatic query_at(input logic [31:0] t);
    req_t r;
    r.mode            = MODE_QUERY;
    r.point_index     = $urandom_range(0, 63);
    r.time_value      = t;
    r.point_amplitude = $urandom;
    queries_sent++;
    send_request(r);
  endtask

  // drop start and hold until every pending request has answered
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (pending_count != 0 || busy);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_points(input logic [CNT_W-1:0] n);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= n;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    active_n = (n > MAX_POINTS) ? MAX_POINTS : n;
    table_settings++;
  endtask

  function automatic logic [31:0] query_time_pick();
    int unsigned k;
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (active_n == 0 || sel >= 94) return $urandom;
    if (sel < 55 && active_n >= 2) begin
      k = $urandom_range(0, active_n - 2);
      return $urandom_range(shadow_time[k], shadow_time[k+1]);
    end
    if (sel < 72) return shadow_time[$urandom_range(0, active_n - 1)];
    if (sel < 80) return $urandom_range(0, shadow_time[0]);
    if (sel < 88) return $urandom_range(shadow_time[active_n-1], 32'hFFFF_FFFF);
    if (sel < 91) return '0;
    return '1;
  endfunction

  task automatic build_table(input int unsigned n);
    logic [31:0] tv [MAX_POINTS];
    logic [31:0] amp;
    logic [31:0] hold;
    int unsigned shape;
    int unsigned base;
    int unsigned j;
    bit          reverse;
    shape = $urandom_range(0, 9);
    base  = $urandom_range(0, 32'hF000_0000);
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        tv[i] = (shape < 2) ? $urandom : base;
      end else begin
        case (shape)
          0, 1:       tv[i] = $urandom;
          2, 3, 4, 5: tv[i] = tv[i-1] + $urandom_range(1, 4000);
          6, 7:       tv[i] = tv[i-1] + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 4000));
          default:    tv[i] = base + $urandom_range(0, 20000);
        endcase
      end
    end
    if (shape < 2) begin
      for (int i = 1; i < n; i++) begin
        hold = tv[i];
        j = i;
        while (j > 0 && tv[j-1] > hold) begin
          tv[j] = tv[j-1];
          j--;
        end
        tv[j] = hold;
      end
    end
    reverse = $urandom_range(0, 1);
    for (int i = 0; i < n; i++) begin
      j = reverse ? n - 1 - i : i;
      case ($urandom_range(0, 9))
        0:       amp = 32'h8000_0000;
        1:       amp = 32'h7FFF_FFFF;
        2, 3:    amp = $urandom_range(0, 32'h0003_0000);
        default: amp = $urandom;
      endcase
      load_point(6'(j), tv[j], amp);
    end
  endtask

  initial begin
    int unsigned n_sel;
    int unsigned nq;
    int unsigned phase;
    int unsigned sel;
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_i          = '0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    active_n       = 0;
    burst_left     = 1;
    items_sent     = 0;
    loads_sent     = 0;
    queries_sent   = 0;
    table_settings = 0;
    phase          = 0;
    for (int i = 0; i < MAX_POINTS; i++) shadow_time[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    query_at(32'd5);
    load_point(6'd0, 32'd1000, 32'h8000_0000);
    set_points(7'd1);
    query_at(32'd0);
    query_at(32'hFFFF_FFFF);
    query_at(32'd1000);
    load_point(6'd1, 32'd2000, 32'h7FFF_FFFF);
    load_point(6'd2, 32'd2000, 32'h0001_0000);
    load_point(6'd3, 32'hFFFF_FFFF, 32'hFFFF_0000);
    load_point(6'd63, 32'hFFFF_FFFF, 32'h7FFF_FFFF);
    set_points(7'd4);
    query_at(32'd999);
    query_at(32'd1000);
    query_at(32'd1001);
    query_at(32'd1500);
    query_at(32'd2000);
    query_at(32'd2001);
    query_at(32'hFFFF_FFFE);
    query_at(32'hFFFF_FFFF);
    load_point(6'd1, 32'd500, 32'h0000_0000);
    query_at(32'd1500);
    set_points(7'd2);
    query_at(32'd700);
    query_at(32'd1200);

    while (items_sent < ITEM_TARGET) begin
      if (phase == 0) begin
        n_sel = MAX_POINTS;
      end else if (phase == 1) begin
        n_sel = 127;
      end else begin
        sel = $urandom_range(0, 99);
        if (sel < 6)       n_sel = 0;
        else if (sel < 12) n_sel = 1;
        else if (sel < 75) n_sel = $urandom_range(2, 8);
        else if (sel < 93) n_sel = $urandom_range(9, 32);
        else if (sel < 97) n_sel = $urandom_range(33, 64);
        else               n_sel = $urandom_range(65, 127);
      end
      build_table((n_sel > MAX_POINTS) ? MAX_POINTS : n_sel);
      set_points(n_sel[CNT_W-1:0]);
      nq = $urandom_range(8, 30);
      repeat (nq) begin
        if ($urandom_range(0, 9) == 0)
          load_point(6'($urandom_range(0, 63)),
                     $urandom_range(0, 1) ? query_time_pick() : $urandom, $urandom);
        else
          query_at(query_time_pick());
      end
      phase++;
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    $display("run summary: %0d breakpoint loads and %0d queries over %0d table sizes,",
             loads_sent, queries_sent, table_settings);
    $display("run summary: empty, single, full and over-range counts, sorted and unsorted tables");
    if (mismatch_count == 0) begin
      $display("tb_piecewise_linear_table_interp_unit: clean");
    end else begin
      $display("tb_piecewise_linear_table_interp_unit: errors");
    end
    $finish;
  end

endmodule
